FILE: sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants for the k-way merge heap
// Operation codes, default sizes, and the command and status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

	// default sizes for the top-level parameters
	localparam int NUM_LISTS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// width of the source tag carried with every entry
	localparam int SRC_W = 4;

	// operation select carried in tuser
	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_START   = 2'd1,
		MODE_REFILL  = 2'd2,
		MODE_EXHAUST = 2'd3
	} kwm_mode_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;      // capture the accepted input item
		logic ins_init;   // place the new entry in the hole at the tail
		logic ins_put;    // write the held entry at the hole (root reached)
		logic rd_parent;  // read the parent of the hole
		logic ins_step;   // compare with parent, move parent down or settle
		logic pop_rd;     // read root and tail entries
		logic pop_take;   // capture root, shrink heap, hold tail entry
		logic sd_rd;      // read both children of the hole
		logic sd_step;    // compare children, move winner up or settle
		logic emit;       // load the output register
	} kwm_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		kwm_mode_t mode;      // operation of the current item
		logic      full;      // no room for another entry
		logic      empty;     // no entries held
		logic      cnt_one;   // exactly one entry held
		logic      idx_zero;  // hole is at the root
		logic      ins_done;  // held entry does not order before its parent
		logic      sd_done;   // no child orders before the held entry
	} kwm_sts_t;

endpackage

`default_nettype wire

FILE: sv/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram: generic RAM, one write port and two registered read ports
// Read data is registered and appears in the cycle after the address; a read of the location
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

FILE: sv/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath: heap storage, hole index, entry count and result registers
// Sifts move a hole through the heap: the entry being placed is held in a
// register and only the entries that move are written back.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_datapath #(
	parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
	parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kwm_pkg::kwm_cmd_t                 cmd,
	output kwm_pkg::kwm_sts_t                      sts,
	input  wire kwm_pkg::kwm_mode_t                in_mode,
	input  wire logic signed [VALUE_WIDTH-1:0]     in_value,
	input  wire logic        [kwm_pkg::SRC_W-1:0]  in_source,
	output logic signed      [VALUE_WIDTH-1:0]     out_value,
	output logic             [kwm_pkg::SRC_W-1:0]  out_source,
	output logic                                   out_empty
);

	localparam int AW = $clog2(NUM_LISTS);
	localparam int CW = $clog2(NUM_LISTS + 1);
	localparam int XW = AW + 2;
	localparam int SW = kwm_pkg::SRC_W;
	localparam int EW = VALUE_WIDTH + SW;

	// true if entry a orders strictly before entry b
	function automatic logic before_f(
		input logic [VALUE_WIDTH-1:0] av,
		input logic [SW-1:0]          as,
		input logic [VALUE_WIDTH-1:0] bv,
		input logic [SW-1:0]          bs
	);
		logic lt;
		lt = ($signed(av) < $signed(bv)) || ((av == bv) && (as < bs));
		return lt;
	endfunction

	kwm_pkg::kwm_mode_t     mode_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [SW-1:0]          src_q;
	logic [CW-1:0]          cnt_q;
	logic [SW-1:0]          last_src_q;
	logic [AW-1:0]          idx_q;
	logic [VALUE_WIDTH-1:0] hold_v_q;
	logic [SW-1:0]          hold_s_q;
	logic [VALUE_WIDTH-1:0] pop_v_q;
	logic [SW-1:0]          pop_s_q;
	logic [VALUE_WIDTH-1:0] out_v_q;
	logic [SW-1:0]          out_s_q;
	logic                   out_e_q;

	logic                   we;
	logic [AW-1:0]          waddr;
	logic [EW-1:0]          wdata;
	logic [AW-1:0]          raddr_a;
	logic [AW-1:0]          raddr_b;
	logic [EW-1:0]          rdata_a;
	logic [EW-1:0]          rdata_b;

	logic [VALUE_WIDTH-1:0] a_v;
	logic [SW-1:0]          a_s;
	logic [VALUE_WIDTH-1:0] b_v;
	logic [SW-1:0]          b_s;
	logic [AW-1:0]          parent;
	logic [XW-1:0]          lc;
	logic [XW-1:0]          rc;
	logic [XW-1:0]          cnt_x;
	logic [CW-1:0]          cnt_m1;
	logic                   hold_lt_par;
	logic                   l_win;
	logic                   r_win;
	logic [VALUE_WIDTH-1:0] pick_v;
	logic [SW-1:0]          pick_s;

	// entry storage
	kwm_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_LISTS)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// tree navigation and comparisons
	always_comb begin
		{a_v, a_s}  = rdata_a;
		{b_v, b_s}  = rdata_b;
		parent      = AW'((idx_q - AW'(1)) >> 1);
		lc          = {1'b0, idx_q, 1'b1};
		rc          = lc + XW'(1);
		cnt_x       = XW'(cnt_q);
		cnt_m1      = cnt_q - CW'(1);
		hold_lt_par = before_f(hold_v_q, hold_s_q, a_v, a_s);
		l_win       = (lc < cnt_x) && before_f(a_v, a_s, hold_v_q, hold_s_q);
		pick_v      = l_win ? a_v : hold_v_q;
		pick_s      = l_win ? a_s : hold_s_q;
		r_win       = (rc < cnt_x) && before_f(b_v, b_s, pick_v, pick_s);
	end

	// memory address and write selection
	always_comb begin
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = {hold_v_q, hold_s_q};
		raddr_a = '0;
		raddr_b = '0;
		if (cmd.ins_put) begin
			we = 1'b1;
		end
		if (cmd.ins_step) begin
			we = 1'b1;
			if (hold_lt_par) begin
				wdata = rdata_a;
			end
		end
		if (cmd.sd_step) begin
			we = 1'b1;
			if (r_win) begin
				wdata = rdata_b;
			end else if (l_win) begin
				wdata = rdata_a;
			end
		end
		if (cmd.rd_parent) begin
			raddr_a = parent;
		end
		if (cmd.pop_rd) begin
			raddr_b = cnt_m1[AW-1:0];
		end
		if (cmd.sd_rd) begin
			raddr_a = lc[AW-1:0];
			raddr_b = rc[AW-1:0];
		end
	end

	// status to the controller
	always_comb begin
		sts.mode     = mode_q;
		sts.full     = (cnt_q == CW'(NUM_LISTS));
		sts.empty    = (cnt_q == '0);
		sts.cnt_one  = (cnt_q == CW'(1));
		sts.idx_zero = (idx_q == '0);
		sts.ins_done = !hold_lt_par;
		sts.sd_done  = !(l_win || r_win);
	end

	// control state: operation, entry count and last popped source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= kwm_pkg::MODE_LOAD;
			cnt_q      <= '0;
			last_src_q <= '0;
		end else begin
			if (cmd.latch) begin
				mode_q <= in_mode;
			end
			if (cmd.ins_init) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.pop_take) begin
				cnt_q      <= cnt_m1;
				last_src_q <= a_s;
			end
		end
	end

	// payload: input latch, held entry, hole index, results
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			val_q <= in_value;
			src_q <= in_source;
		end
		if (cmd.ins_init) begin
			hold_v_q <= val_q;
			hold_s_q <= (mode_q == kwm_pkg::MODE_REFILL) ? last_src_q : src_q;
			idx_q    <= cnt_q[AW-1:0];
		end
		if (cmd.ins_step && hold_lt_par) begin
			idx_q <= parent;
		end
		if (cmd.pop_take) begin
			pop_v_q  <= a_v;
			pop_s_q  <= a_s;
			hold_v_q <= b_v;
			hold_s_q <= b_s;
			idx_q    <= '0;
		end
		if (cmd.sd_step) begin
			if (r_win) begin
				idx_q <= rc[AW-1:0];
			end else if (l_win) begin
				idx_q <= lc[AW-1:0];
			end
		end
		if (cmd.emit) begin
			out_v_q <= pop_v_q;
			out_s_q <= pop_s_q;
			out_e_q <= (cnt_q == '0);
		end
	end

	assign out_value  = $signed(out_v_q);
	assign out_source = out_s_q;
	assign out_empty  = out_e_q;

	// the heap never holds more entries than it has room for
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_LISTS))
		else $error("entry count above capacity");

	// every write lands inside the live part of the heap
	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (XW'(waddr) < cnt_x))
		else $error("heap write beyond entry count");

	// a pop is only taken from a non-empty heap
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_take |-> (cnt_q != '0))
		else $error("pop from empty heap");

	// a pop shrinks the heap by exactly one
	a_pop_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_take |=> (cnt_q == CW'($past(cnt_q) - CW'(1))))
		else $error("pop did not shrink heap by one");

endmodule

`default_nettype wire

FILE: sv/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl: sequencer for insert, pop and sift steps
// Walks each operation through read and compare steps and owns the stream
// handshakes and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kwm_pkg::kwm_cmd_t      cmd,
	input  wire kwm_pkg::kwm_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_START,
		ST_INS_RD,
		ST_INS_CMP,
		ST_POP_CHK,
		ST_POP_RD,
		ST_POP_TAKE,
		ST_SD_RD,
		ST_SD_CMP,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	state_t after_ins;
	logic   out_valid_q;

	// where to go once an insert is finished or skipped
	assign after_ins = (sts.mode == kwm_pkg::MODE_LOAD) ? ST_IDLE : ST_POP_CHK;

	// next state and datapath commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_INS_START;
				end
			end
			ST_INS_START: begin
				if (sts.mode == kwm_pkg::MODE_START || sts.mode == kwm_pkg::MODE_EXHAUST) begin
					state_nxt = ST_POP_CHK;
				end else if (sts.full) begin
					state_nxt = after_ins;
				end else begin
					cmd.ins_init = 1'b1;
					state_nxt    = ST_INS_RD;
				end
			end
			ST_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.ins_put = 1'b1;
					state_nxt   = after_ins;
				end else begin
					cmd.rd_parent = 1'b1;
					state_nxt     = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				cmd.ins_step = 1'b1;
				state_nxt    = sts.ins_done ? after_ins : ST_INS_RD;
			end
			ST_POP_CHK: begin
				state_nxt = sts.empty ? ST_IDLE : ST_POP_RD;
			end
			ST_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_nxt  = ST_POP_TAKE;
			end
			ST_POP_TAKE: begin
				cmd.pop_take = 1'b1;
				state_nxt    = sts.cnt_one ? ST_EMIT : ST_SD_RD;
			end
			ST_SD_RD: begin
				cmd.sd_rd = 1'b1;
				state_nxt = ST_SD_CMP;
			end
			ST_SD_CMP: begin
				cmd.sd_step = 1'b1;
				state_nxt   = sts.sd_done ? ST_EMIT : ST_SD_RD;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/k_way_merge_heap.sv
// ----------------------------------------------------------------------------
// k_way_merge_heap: k-way merge of sorted lists through a binary min-heap
// Holds (value, source) entries ordered by signed value, lower source first
// on ties; load inserts, refill inserts then pops, start/exhausted pop the minimum.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)           tuser / tlast
//  s_*      in   item_value, source_index     tuser: mode
//  m_*      out  out_value, out_source        tlast: heap_empty
//
//  A load moves the hole up one heap level per parent read and compare step
//  and writes the held entry directly once the hole reaches the root; a pop
//  reads root and tail entries, then sifts down with one read and one compare
//  step per level, skipped when it takes the last entry; a refill is a load
//  followed by a pop. An entry moves at most clog2(NUM_LISTS) levels, through
//  the single write port of the entry RAM. Popping an empty heap gives no result.
//  Reset clears the entry count, the last source and the output valid flag.
//  A result waiting on m_tready does not block the next input transfer; the
//  following pop then waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_merge_heap #(
	parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
	parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic s_tvalid,
	output logic      s_tready,
	// item_value, source_index, zero padding
	input  wire logic [((VALUE_WIDTH + kwm_pkg::SRC_W + 7) / 8) * 8 - 1:0] s_tdata,
	// mode
	input  wire logic [1:0] s_tuser,

	output logic      m_tvalid,
	input  wire logic m_tready,
	// out_value, out_source, zero padding
	output logic [((VALUE_WIDTH + kwm_pkg::SRC_W + 7) / 8) * 8 - 1:0] m_tdata,
	// heap_empty
	output logic      m_tlast
);

	localparam int DW = ((VALUE_WIDTH + kwm_pkg::SRC_W + 7) / 8) * 8;

	kwm_pkg::kwm_cmd_t                cmd;
	kwm_pkg::kwm_sts_t                sts;
	logic signed [VALUE_WIDTH-1:0]    out_value;
	logic        [kwm_pkg::SRC_W-1:0] out_source;

	// sequencer
	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// heap storage and arithmetic
	kwm_datapath #(
		.NUM_LISTS   (NUM_LISTS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (kwm_pkg::kwm_mode_t'(s_tuser)),
		.in_value   ($signed(s_tdata[VALUE_WIDTH-1:0])),
		.in_source  (s_tdata[VALUE_WIDTH +: kwm_pkg::SRC_W]),
		.out_value  (out_value),
		.out_source (out_source),
		.out_empty  (m_tlast)
	);

	// result packing
	assign m_tdata = DW'({out_source, out_value});

endmodule

`default_nettype wire

FILE: tb/k_way_merge_heap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_heap_tb: self-checking bench for the k-way merge heap
// Drives merge sessions (load list heads, start, refill or exhaust after each
// result), random noise and full-heap cases through the input stream. A
// scoreboard class mirrors the heap and checks every output transfer against
// the predicted merged order.
// ----------------------------------------------------------------------------

module k_way_merge_heap_tb;
	import kwm_pkg::*;

	localparam int     VW           = VALUE_WIDTH_DEF;
	localparam int     LISTS        = NUM_LISTS_DEF;
	localparam int     DATA_W       = ((VW + SRC_W + 7) / 8) * 8;
	localparam int     MAX_LEN      = 8;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     DRAIN_CYCLES = 60;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam longint VAL_MAX      = (longint'(1) << (VW - 1)) - 1;
	localparam longint VAL_MIN      = -(longint'(1) << (VW - 1));

	typedef struct {
		logic signed [VW-1:0] value;
		logic [SRC_W-1:0]     source;
		logic                 empty;
	} merged_t;

	// heap mirror and queue of expected merged results
	class merge_scoreboard;
		logic signed [VW-1:0] heap_val [LISTS];
		logic [SRC_W-1:0]     heap_src [LISTS];
		int                   fill;
		logic [SRC_W-1:0]     last_src;
		merged_t              merged_q [$];
		int                   errors;

		function new();
			fill     = 0;
			last_src = '0;
			errors   = 0;
		endfunction

		function void report(string msg);
			$display("[%0t] merge mismatch: %s", $time, msg);
			errors++;
		endfunction

		// lower value first, lower source on ties
		function bit ahead(int i, int j);
			if (heap_val[i] != heap_val[j])
				return heap_val[i] < heap_val[j];
			return heap_src[i] < heap_src[j];
		endfunction

		function void swap(int i, int j);
			logic signed [VW-1:0] v;
			logic [SRC_W-1:0]     s;
			v           = heap_val[i];
			s           = heap_src[i];
			heap_val[i] = heap_val[j];
			heap_src[i] = heap_src[j];
			heap_val[j] = v;
			heap_src[j] = s;
		endfunction

		// sift-up insert, dropped when full
		function void push(logic signed [VW-1:0] value, logic [SRC_W-1:0] src);
			int i;
			int p;
			if (fill >= LISTS)
				return;
			i           = fill;
			heap_val[i] = value;
			heap_src[i] = src;
			fill++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!ahead(i, p))
					break;
				swap(i, p);
				i = p;
			end
		endfunction

		// one accepted input transfer
		function void note_input(kwm_mode_t mode, logic signed [VW-1:0] value,
				logic [SRC_W-1:0] src);
			merged_t r;
			int      i;
			int      l;
			int      m;
			if (mode == MODE_LOAD) begin
				push(value, src);
				return;
			end
			if (mode == MODE_REFILL)
				push(value, last_src);
			if (fill == 0)
				return;
			r.value  = heap_val[0];
			r.source = heap_src[0];
			fill--;
			if (fill > 0) begin
				heap_val[0] = heap_val[fill];
				heap_src[0] = heap_src[fill];
				i = 0;
				while (1) begin
					l = 2 * i + 1;
					m = i;
					if (l < fill && ahead(l, m))
						m = l;
					if (l + 1 < fill && ahead(l + 1, m))
						m = l + 1;
					if (m == i)
						break;
					swap(i, m);
					i = m;
				end
			end
			last_src = r.source;
			r.empty  = (fill == 0);
			merged_q.insert(merged_q.size(), r);
		endfunction

		// one accepted output transfer
		function void check_result(logic signed [VW-1:0] value, logic [SRC_W-1:0] src,
				logic empty);
			merged_t r;
			if (merged_q.size() == 0) begin
				report($sformatf("result %0d/%0d with nothing pending", value, src));
				return;
			end
			r = merged_q.pop_front();
			if (value !== r.value)
				report($sformatf("out_value %0d, wanted %0d", value, r.value));
			if (src !== r.source)
				report($sformatf("out_source %0d, wanted %0d", src, r.source));
			if (empty !== r.empty)
				report($sformatf("heap_empty %0b, wanted %0b", empty, r.empty));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // item_value, source_index, zero padding
	logic [1:0]        s_tuser;   // mode
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // out_value, out_source, zero padding
	logic              m_tlast;

	merge_scoreboard sb;
	bit              no_idle;
	bit              hold_req;
	int              items_sent;

	k_way_merge_heap i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one input transfer, after a random gap
	task automatic send_item(kwm_mode_t mode, logic [VW-1:0] value, logic [SRC_W-1:0] src);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {src, value};
		do @(posedge clk); while (!s_tready);
		sb.note_input(mode, value, src);
		items_sent++;
	endtask

	// pop until the mirror says the heap is empty
	task automatic flush_heap();
		while (sb.fill > 0)
			send_item(MODE_EXHAUST, VW'($urandom), SRC_W'($urandom));
	endtask

	// random modes, loads favored so the heap overflows now and then
	task automatic noise_burst(int count);
		int m;
		repeat (count) begin
			m = $urandom_range(0, 5);
			send_item(m < 3 ? MODE_LOAD : kwm_mode_t'(2'(m - 2)), VW'($urandom),
				SRC_W'($urandom));
		end
	endtask

	// well-formed merge of at least one sorted list; each list is used with odds k in LISTS, k up to kmax
	task automatic merge_session(int kmax);
		logic [VW-1:0]    lists [LISTS][MAX_LEN];
		int               len [LISTS];
		int               pos [LISTS];
		int               k;
		int               s;
		int               n;
		int               span;
		int               offset;
		longint           v;
		logic [SRC_W-1:0] ls;
		k = $urandom_range(1, kmax);
		for (s = 0; s < LISTS; s++) begin
			pos[s] = 0;
			len[s] = ($urandom_range(0, LISTS - 1) < k) ? $urandom_range(1, MAX_LEN) : 0;
		end
		s = $urandom_range(0, LISTS - 1);
		if (len[s] == 0)
			len[s] = 1;
		// ascending lists: wide spread, ties, or pinned to either extreme
		for (s = 0; s < LISTS; s++) begin
			case ($urandom_range(0, 3))
				0: begin
					v    = longint'($signed(VW'($urandom)));
					span = 1 << 26;
				end
				1: begin
					v    = longint'($urandom_range(0, 40)) - 20;
					span = 2;
				end
				2: begin
					v    = VAL_MIN;
					span = 2;
				end
				default: begin
					v    = VAL_MAX - 12;
					span = 3;
				end
			endcase
			for (n = 0; n < len[s]; n++) begin
				lists[s][n] = v[VW-1:0];
				v = v + longint'($urandom_range(0, span));
				if (v > VAL_MAX)
					v = VAL_MAX;
			end
		end
		// heads in a rotated order
		offset = $urandom_range(0, LISTS - 1);
		for (n = 0; n < LISTS; n++) begin
			s = (offset + n) % LISTS;
			if (len[s] > 0) begin
				send_item(MODE_LOAD, lists[s][0], SRC_W'(s));
				pos[s] = 1;
			end
		end
		send_item(MODE_START, VW'($urandom), SRC_W'($urandom));
		// refill from the list just emitted, or report it exhausted
		while (1) begin
			ls = sb.last_src;
			if (pos[ls] < len[ls]) begin
				send_item(MODE_REFILL, lists[ls][pos[ls]], SRC_W'($urandom));
				pos[ls]++;
			end else if (sb.fill > 0) begin
				send_item(MODE_EXHAUST, VW'($urandom), SRC_W'($urandom));
			end else begin
				break;
			end
		end
	endtask

	// output ready with random stalls and one long hold-off
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = stall + HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[VW-1:0], m_tdata[VW+SRC_W-1:VW], m_tlast);
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL k_way_merge_heap");
		$finish;
	end

	// stimulus
	initial begin
		int i;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = MODE_LOAD;
		no_idle    = 1'b0;
		hold_req   = 1'b0;
		items_sent = 0;
		sb         = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on an empty heap give nothing
		send_item(MODE_START, '0, '0);
		send_item(MODE_EXHAUST, VW'($urandom), SRC_W'($urandom));
		// refill before any pop, into the empty heap: tagged with source zero
		send_item(MODE_REFILL, VW'(5), SRC_W'(11));
		// extremes and ties, then fill to capacity
		send_item(MODE_LOAD, {1'b0, {(VW - 1){1'b1}}}, SRC_W'(15));
		send_item(MODE_LOAD, {1'b1, {(VW - 1){1'b0}}}, SRC_W'(0));
		send_item(MODE_LOAD, '0, SRC_W'(7));
		send_item(MODE_LOAD, '1, SRC_W'(3));
		send_item(MODE_LOAD, VW'(5), SRC_W'(9));
		send_item(MODE_LOAD, VW'(5), SRC_W'(2));
		send_item(MODE_LOAD, VW'(5), SRC_W'(12));
		for (i = 0; i < LISTS - 7; i++)
			send_item(MODE_LOAD, VW'($urandom), SRC_W'($urandom));
		// heap full: this load is dropped
		send_item(MODE_LOAD, {1'b1, {(VW - 1){1'b0}}}, SRC_W'(1));
		// refill on a full heap drops the insert but still pops
		send_item(MODE_REFILL, '1, SRC_W'(4));
		send_item(MODE_EXHAUST, '0, '0);
		send_item(MODE_START, '1, '1);
		flush_heap();

		// merge sessions with idling on both sides
		while (items_sent < 160)
			merge_session(LISTS);

		// receiver holds off while the sender keeps offering
		hold_req = 1'b1;
		no_idle  = 1'b1;
		merge_session(LISTS);
		merge_session(LISTS);
		no_idle  = 1'b0;

		// sender pauses until every result is out
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.merged_q.size() > 0);

		// back-to-back stretch
		no_idle = 1'b1;
		while (items_sent < 300)
			merge_session(LISTS);
		no_idle = 1'b0;

		// broken sequences and overflow
		noise_burst(60);
		flush_heap();

		while (items_sent < 500)
			merge_session(LISTS);
		s_tvalid <= 1'b0;

		while (sb.merged_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.merged_q.size() == 0)
			$display("PASS k_way_merge_heap");
		else
			$display("FAIL k_way_merge_heap");
		$finish;
	end

endmodule
